>>> hdl/key_event_to_midi_note_macros.svh
// Assertion macros shared by the key event to MIDI note block.
`ifndef KEY_EVENT_TO_MIDI_NOTE_MACROS_SVH
`define KEY_EVENT_TO_MIDI_NOTE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define KENM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kenm: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define KENM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kenm: next-cycle check failed");
`else
`define KENM_ASSERT_NOW(label, clk, rst, ante, cons)
`define KENM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/kenm_pkg.sv
// Shared constants, key table and types for the key event to MIDI note block.
package kenm_pkg;

   localparam int NUM_KEYS  = 24;
   localparam int KEY_IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

   localparam logic [15:0] KEY_BRACKET_LEFT  = 16'h005b;
   localparam logic [15:0] KEY_BRACKET_RIGHT = 16'h005d;
   localparam logic [15:0] KEY_ESCAPE        = 16'hff1b;

   // keysym for semitones 0..23: z s x d c v g b h n j m, q 2 w 3 e r 5 t 6 y 7 u
   localparam logic [15:0] KEY_CODES [24] = '{
      16'h007a, 16'h0073, 16'h0078, 16'h0064, 16'h0063, 16'h0076,
      16'h0067, 16'h0062, 16'h0068, 16'h006e, 16'h006a, 16'h006d,
      16'h0071, 16'h0032, 16'h0077, 16'h0033, 16'h0065, 16'h0072,
      16'h0035, 16'h0074, 16'h0036, 16'h0079, 16'h0037, 16'h0075
   };

   localparam logic signed [4:0] SHIFT_MAX = 5'sd11;
   localparam logic signed [4:0] SHIFT_MIN = -5'sd11;
   localparam logic [6:0]        NOTE_MAX  = 7'd127;
   localparam logic [6:0]        BASE_NOTE_RESET = 7'd60;
   localparam int                SUM_W     = 10;

   // command kinds produced by the front end
   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_OCT_DN  = 3'd1;
   localparam logic [2:0] KIND_OCT_UP  = 3'd2;
   localparam logic [2:0] KIND_ALL_OFF = 3'd3;
   localparam logic [2:0] KIND_KEY     = 3'd4;

   // result actions
   localparam logic [1:0] ACT_NONE    = 2'd0;
   localparam logic [1:0] ACT_ON      = 2'd1;
   localparam logic [1:0] ACT_OFF     = 2'd2;
   localparam logic [1:0] ACT_ALL_OFF = 2'd3;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   typedef struct packed {
      logic [2:0]           kind;
      logic [KEY_IDX_W-1:0] key;
      logic                 press;
   } cmd_type;

   typedef struct packed {
      logic              full;
      logic [QCNT_W-1:0] count;
   } qstat_type;

endpackage

>>> hdl/kenm_front.sv
// Front end: accept key events and classify them into commands.
module kenm_front
   import kenm_pkg::*;
(
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] key_code
   input  logic [0:0]  req_tuser,   // [0] is_press
   input  qstat_type   qstat,
   output logic        push_valid,
   output cmd_type     push_data
);

   logic                 hit;
   logic [KEY_IDX_W-1:0] hit_idx;
   logic                 press;

   assign press      = req_tuser[0];
   assign req_tready = !qstat.full && !reset;
   assign push_valid = req_tvalid && req_tready;

   // codes in the table are unique, so at most one compare matches
   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (req_tdata == KEY_CODES[i]) begin
            hit     = 1'b1;
            hit_idx = KEY_IDX_W'(i);
         end
      end
   end

   always_comb begin
      push_data.key   = hit_idx;
      push_data.press = press;
      if (press && req_tdata == KEY_BRACKET_LEFT) begin
         push_data.kind = KIND_OCT_DN;
      end else if (press && req_tdata == KEY_BRACKET_RIGHT) begin
         push_data.kind = KIND_OCT_UP;
      end else if (press && req_tdata == KEY_ESCAPE) begin
         push_data.kind = KIND_ALL_OFF;
      end else if (hit) begin
         push_data.kind = KIND_KEY;
      end else begin
         push_data.kind = KIND_NONE;
      end
   end

endmodule

>>> hdl/kenm_queue.sv
// Two-entry command queue between front end and back end.
module kenm_queue
   import kenm_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  cmd_type   push_data,
   output logic      pop_valid,
   input  logic      pop_ready,
   output cmd_type   pop_data,
   output qstat_type qstat
);

   cmd_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff,  count_in;
   logic                pop_fire;

   assign pop_valid = (count_ff != '0);
   assign pop_fire  = pop_valid && pop_ready;
   assign pop_data  = slot_ff[rd_ptr_ff];

   assign qstat.count = count_ff;
   assign qstat.full  = (count_ff == QCNT_W'(QDEPTH));

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop_fire   ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push_valid, pop_fire})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/kenm_back.sv
// Back end: octave shift, per-key held flags and notes, and the result register.
module kenm_back
   import kenm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic [6:0]  csr_data,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  cmd_type     pop_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_action,
   output logic [6:0]  rsp_note
);

   logic [6:0]           base_note_ff, base_note_in;
   logic signed [4:0]    shift_ff, shift_in;
   logic [NUM_KEYS-1:0]  held_ff, held_in;
   logic [6:0]           key_note_ff [NUM_KEYS];
   logic                 note_we;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_action_ff, rsp_action_in;
   logic [6:0]           rsp_note_ff, rsp_note_in;
   logic                 pop_fire;

   logic signed [SUM_W-1:0] shift_ext, shift12, sum;
   logic [6:0]              clamped;
   logic                    key_held;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign pop_fire  = pop_valid && pop_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_action = rsp_action_ff;
   assign rsp_note   = rsp_note_ff;

   assign base_note_in = csr_valid ? csr_data : base_note_ff;

   // base + 12 * shift + semitone, then clamp to the note range
   always_comb begin
      shift_ext = {{(SUM_W-5){shift_ff[4]}}, shift_ff};
      shift12   = (shift_ext <<< 3) + (shift_ext <<< 2);
      sum       = $signed({{(SUM_W-7){1'b0}}, base_note_ff}) + shift12
                + $signed({{(SUM_W-KEY_IDX_W){1'b0}}, pop_data.key});
      if (sum < 0) begin
         clamped = '0;
      end else if (sum > $signed({{(SUM_W-7){1'b0}}, NOTE_MAX})) begin
         clamped = NOTE_MAX;
      end else begin
         clamped = sum[6:0];
      end
   end

   assign key_held = held_ff[pop_data.key];

   always_comb begin
      shift_in      = shift_ff;
      held_in       = held_ff;
      note_we       = 1'b0;
      rsp_action_in = rsp_action_ff;
      rsp_note_in   = rsp_note_ff;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (pop_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = ACT_NONE;
         rsp_note_in   = '0;
         case (pop_data.kind)
            KIND_OCT_DN: begin
               if (shift_ff > SHIFT_MIN) shift_in = shift_ff - 5'sd1;
            end
            KIND_OCT_UP: begin
               if (shift_ff < SHIFT_MAX) shift_in = shift_ff + 5'sd1;
            end
            KIND_ALL_OFF: begin
               held_in       = '0;
               rsp_action_in = ACT_ALL_OFF;
            end
            KIND_KEY: begin
               if (pop_data.press && !key_held) begin
                  held_in[pop_data.key] = 1'b1;
                  note_we               = 1'b1;
                  rsp_action_in         = ACT_ON;
                  rsp_note_in           = clamped;
               end else if (!pop_data.press && key_held) begin
                  held_in[pop_data.key] = 1'b0;
                  rsp_action_in         = ACT_OFF;
                  rsp_note_in           = key_note_ff[pop_data.key];
               end
            end
            default: begin
               rsp_action_in = ACT_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_note_ff <= BASE_NOTE_RESET;
         shift_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_note_ff <= base_note_in;
         shift_ff     <= shift_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_action_ff <= rsp_action_in;
      rsp_note_ff   <= rsp_note_in;
      if (note_we) begin
         key_note_ff[pop_data.key] <= clamped;
      end
   end

endmodule

>>> hdl/key_event_to_midi_note.sv
// Key event to MIDI note mapper, top level.
// Path: an accepted event is queued, then its result is registered in the back end.
// Throughput: one key event per cycle while rsp is ready, set by the single back-end update
//   of octave and held flags; while rsp is stalled, the two-entry queue accepts until full.
// Reset (synchronous, active high): queue empty, no result pending, octave shift zero,
//   all held flags cleared, base note 60. Stored notes keep their contents.
module key_event_to_midi_note
   import kenm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // key event channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] key_code
   input  logic [0:0]  req_tuser,   // [0] is_press
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] note, [7] zero
   output logic [1:0]  rsp_tuser,   // [1:0] action
   // base note register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data     // [6:0] base_note
);

`include "key_event_to_midi_note_macros.svh"

   cmd_type   push_data;
   cmd_type   pop_data;
   qstat_type qstat;
   logic      push_valid;
   logic      pop_valid;
   logic      pop_ready;
   logic      pop_fire;
   logic      q_grow;
   logic      csr_fire;
   logic [6:0] note;

   // the register is always ready; writes must come only while the block is idle (not enforced)
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // classify each transfer into a command
   kenm_front u_front (
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .qstat      (qstat),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // decouple front and back
   kenm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .qstat      (qstat)
   );

   // apply commands to the key state and hold the result until rsp takes it
   kenm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_fire),
      .csr_data   (csr_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_action (rsp_tuser),
      .rsp_note   (note)
   );

   assign rsp_tdata = {1'b0, note};
   assign pop_fire  = pop_valid && pop_ready;
   assign q_grow    = push_valid && !pop_fire;

   // a command leaves the queue only when the result register can take it
   `KENM_ASSERT_NOW(a_pop_needs_room, clock, reset, pop_fire, !rsp_tvalid || rsp_tready)
   // an accepted transfer is visible to the back end on the next cycle
   `KENM_ASSERT_NEXT(a_push_lands, clock, reset, req_tvalid && req_tready, pop_valid)
   // queue fill tracks pushes without pops
   `KENM_ASSERT_NEXT(a_count_up, clock, reset, q_grow, qstat.count == $past(qstat.count) + 2'd1)
   // a popped command always yields a result next cycle
   `KENM_ASSERT_NEXT(a_pop_gives_rsp, clock, reset, pop_fire, rsp_tvalid)

endmodule

>>> tb/key_event_to_midi_note_test.sv
// Self-checking testbench for the key event to MIDI note mapper.
module key_event_to_midi_note_test;
   timeunit 1ns;
   timeprecision 1ps;

   import kenm_pkg::*;

   localparam int SEMITONES_PER_OCTAVE = 12;
   localparam int CYCLE_LIMIT          = 400000;
   localparam int SETTLE_CYCLES        = 6;    // extra wait after the last predicted result is back
   localparam int HOLD_OFF_CYCLES      = 80;

   // one result: action on tuser, note on tdata
   typedef struct packed {
      logic [1:0] action;
      logic [6:0] note;
   } midi_event_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data   = '0;

   // mirror of the block's state, advanced at each accepted transfer
   logic [6:0]          base_model = BASE_NOTE_RESET;
   logic signed [4:0]   octave     = '0;
   logic [NUM_KEYS-1:0] key_down   = '0;
   logic [6:0]          key_pitch [NUM_KEYS];

   midi_event_type due_midi [$];

   // idle percentages for each side, set per phase
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   // receiver hold-off request: bump the token to start a stall whose length is set by hold_len
   int hold_token = 0;
   int hold_len   = 0;

   int errors        = 0;
   int events_sent   = 0;
   int results_seen  = 0;
   int cycle_count   = 0;
   int base_writes   = 0;
   int low_limit_hit = 0;
   int high_limit_hit = 0;
   int action_count [4] = '{0, 0, 0, 0};

   key_event_to_midi_note dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Work out the result of one key event and advance the mirrored state.
   function automatic midi_event_type map_key_event(input logic [15:0] code, input logic press);
      midi_event_type r;
      int slot;
      int pitch;
      r.action = ACT_NONE;
      r.note   = '0;
      slot     = -1;
      for (int i = 0; i < NUM_KEYS; i++) begin
         if (KEY_CODES[i] == code) slot = i;
      end
      if (press && code == KEY_BRACKET_LEFT) begin
         if (octave > SHIFT_MIN) octave--;
         else low_limit_hit++;
      end else if (press && code == KEY_BRACKET_RIGHT) begin
         if (octave < SHIFT_MAX) octave++;
         else high_limit_hit++;
      end else if (press && code == KEY_ESCAPE) begin
         // stored pitches survive, only the held flags drop
         key_down = '0;
         r.action = ACT_ALL_OFF;
      end else if (slot >= 0) begin
         if (press && !key_down[slot]) begin
            pitch = int'(base_model) + SEMITONES_PER_OCTAVE * int'(octave) + slot;
            if (pitch < 0) pitch = 0;
            if (pitch > int'(NOTE_MAX)) pitch = int'(NOTE_MAX);
            key_down[slot]  = 1'b1;
            key_pitch[slot] = pitch[6:0];
            r.action = ACT_ON;
            r.note   = pitch[6:0];
         end else if (!press && key_down[slot]) begin
            // release sends the pitch stored at press time
            key_down[slot] = 1'b0;
            r.action = ACT_OFF;
            r.note   = key_pitch[slot];
         end
      end
      return r;
   endfunction

   // Watch all three channels at each edge: track config, predict, check.
   always @(posedge clock) begin : watch_channels
      midi_event_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            base_model = csr_data;
            base_writes++;
         end
         if (req_tvalid && req_tready) due_midi.push_back(map_key_event(req_tdata, req_tuser[0]));
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (due_midi.size() == 0) begin
               errors++;
               $display("%0t: unexpected result action %0d note %0d", $time, rsp_tuser,
                        rsp_tdata[6:0]);
            end else begin
               want = due_midi.pop_front();
               action_count[want.action]++;
               if (rsp_tuser !== want.action) begin
                  errors++;
                  $display("%0t: action mismatch, expected %0d, got %0d", $time, want.action,
                           rsp_tuser);
               end
               if (rsp_tdata[6:0] !== want.note) begin
                  errors++;
                  $display("%0t: note mismatch, expected %0d, got %0d", $time, want.note,
                           rsp_tdata[6:0]);
               end
            end
         end
      end
   end

   // Receiver: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin : drive_rsp_ready
      static int hold_left = 0;
      static int token_seen = 0;
      if (hold_token != token_seen) begin
         token_seen = hold_token;
         hold_left  = hold_len;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Watchdog: end the run once the cycle count exceeds CYCLE_LIMIT.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, due_midi.size());
         $display("key_event_to_midi_note_test: done, errors");
         $finish;
      end
   end

   // Offer one key event, idling first at random, and hold it until the transfer.
   // Valid stays high afterwards; the next call replaces or idles it, settle_outputs lowers it.
   task automatic send_key_event(input logic [15:0] code, input logic press);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= code;
      req_tuser[0] <= press;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      events_sent++;
   endtask

   // Stop offering and wait until every predicted result has come back.
   task automatic settle_outputs();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (due_midi.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the base note while the block is idle.
   task automatic write_base_note(input logic [6:0] value);
      settle_outputs();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Plain note on and off with the reset base note, repeats and stray releases.
   task automatic test_note_on_off();
      send_key_event(KEY_CODES[0], 1'b1);
      send_key_event(KEY_CODES[0], 1'b1);           // already held: ignore
      send_key_event(KEY_CODES[0], 1'b0);
      send_key_event(KEY_CODES[0], 1'b0);           // not held: ignore
   endtask

   // Octave keys, escape, and a release after escape.
   task automatic test_special_keys();
      send_key_event(KEY_BRACKET_LEFT, 1'b1);
      send_key_event(KEY_BRACKET_RIGHT, 1'b1);
      send_key_event(KEY_BRACKET_LEFT, 1'b0);
      send_key_event(KEY_BRACKET_RIGHT, 1'b0);
      send_key_event(KEY_ESCAPE, 1'b0);
      send_key_event(KEY_CODES[1], 1'b1);
      send_key_event(KEY_ESCAPE, 1'b1);
      send_key_event(KEY_CODES[1], 1'b0);           // cleared by escape: ignore
   endtask

   // Codes at the ends of the field that map to nothing.
   task automatic test_unmapped_codes();
      send_key_event(16'h0000, 1'b1);
      send_key_event(16'hffff, 1'b1);
      send_key_event(16'hffff, 1'b0);
      send_key_event(16'h0000, 1'b0);
   endtask

   // Base note at both extremes, driving the pitch into both clamps.
   task automatic test_base_extremes();
      write_base_note(7'd127);
      send_key_event(KEY_CODES[NUM_KEYS-1], 1'b1);
      send_key_event(KEY_CODES[NUM_KEYS-1], 1'b0);
      write_base_note(7'd0);
      send_key_event(KEY_BRACKET_LEFT, 1'b1);
      send_key_event(KEY_CODES[0], 1'b1);
      send_key_event(KEY_CODES[0], 1'b0);
      send_key_event(KEY_BRACKET_RIGHT, 1'b1);
   endtask

   // Hold the receiver off while the sender keeps offering, so the input stalls;
   // then pause the sender until every result is back.
   task automatic test_backpressure();
      settle_outputs();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_len     = HOLD_OFF_CYCLES;
      hold_token++;
      for (int i = 0; i < 16; i++) begin
         send_key_event(KEY_CODES[$urandom_range(NUM_KEYS-1)], 1'(i % 2 == 0));
      end
      settle_outputs();
   endtask

   // Mostly musical traffic: presses, releases of held keys, octave runs, escape,
   // with some noise codes mixed in.
   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct,
                                      input logic [6:0] base);
      int stop_at;
      int pick;
      int run;
      int slot;
      logic [15:0] bracket;
      write_base_note(base);
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      stop_at = events_sent + count;
      while (events_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 42) begin
            send_key_event(KEY_CODES[$urandom_range(NUM_KEYS-1)], 1'b1);
         end else if (pick < 78) begin
            // prefer releasing a key that is down
            slot = $urandom_range(NUM_KEYS-1);
            if ($urandom_range(3) != 0 && key_down != '0) begin
               while (!key_down[slot]) slot = $urandom_range(NUM_KEYS-1);
            end
            send_key_event(KEY_CODES[slot], 1'b0);
         end else if (pick < 87) begin
            // octave run, long enough to hit the limits
            run     = $urandom_range(1, 14);
            bracket = $urandom_range(1) ? KEY_BRACKET_RIGHT : KEY_BRACKET_LEFT;
            for (int i = 0; i < run; i++) send_key_event(bracket, $urandom_range(4) != 0);
         end else if (pick < 91) begin
            send_key_event(KEY_ESCAPE, $urandom_range(2) != 0);
         end else begin
            send_key_event(16'($urandom_range(65535)), 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_note_on_off();
      test_special_keys();
      test_unmapped_codes();
      test_base_extremes();
      test_random_traffic(350, 38, 77, 7'($urandom_range(127)));
      test_backpressure();
      test_random_traffic(350, 77, 38, 7'($urandom_range(40, 90)));
      test_random_traffic(350, 0, 0, 7'($urandom_range(127)));

      settle_outputs();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_midi.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $time, due_midi.size());
      end

      $display("covered %0d key events, %0d results: %0d note on, %0d note off, %0d all off,",
               events_sent, results_seen, action_count[ACT_ON], action_count[ACT_OFF],
               action_count[ACT_ALL_OFF]);
      $display("  %0d ignored; %0d base note writes; octave limit reached %0d low, %0d high",
               action_count[ACT_NONE], base_writes, low_limit_hit, high_limit_hit);
      if (errors == 0) begin
         $display("key_event_to_midi_note_test: done, clean");
      end else begin
         $display("key_event_to_midi_note_test: done, errors");
      end
      $finish;
   end

endmodule
